>>> hw/rtl/ipid_pkg.sv
// Shared widths, codes and types of the integer PID controller.
package ipid_pkg;

  // Sample width of the process value, setpoint and control output
  localparam int DATA_WIDTH = 16;

  // Register field widths
  localparam int GAIN_W = 15;
  localparam int DIV_W  = 16;
  localparam int LOW_W  = 16;
  localparam int HIGH_W = 15;

  // Controller state widths
  localparam int INTEG_W = 32;
  localparam int LIM_W   = HIGH_W + DIV_W;
  localparam int ERR_W   = DATA_WIDTH + 1;
  localparam int DER_W   = DATA_WIDTH + 2;

  // Multiply-accumulate and divide widths
  localparam int NUM_TERMS = 3;
  localparam int MCAND_W   = (DER_W > INTEG_W) ? DER_W : INTEG_W;
  localparam int MAG_W     = GAIN_W + MCAND_W + 1;
  localparam int SUM_W     = MAG_W + 1;
  localparam int SAT_W     = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
  localparam int MAC_CNT_W = $clog2(GAIN_W + 1);
  localparam int DIV_CNT_W = $clog2(MAG_W + 1);

  // Configuration word widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Integral saturation bounds
  localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Command codes
  localparam logic CMD_CALC = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_DIVISOR    = 3'd3,
    REG_LIMIT_LOW  = 3'd4,
    REG_LIMIT_HIGH = 3'd5
  } ipid_reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_FINISH
  } ipid_state_e;

  // One gain/operand pair of the multiply-accumulate
  typedef struct packed {
    logic [GAIN_W-1:0]  mpy;
    logic [MCAND_W-1:0] mcand;
  } ipid_term_t;

endpackage

>>> hw/rtl/ipid_if.sv
// Handshake channels of the integer PID controller: input, output and configuration.
interface ipid_in_if import ipid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [DATA_WIDTH-1:0] measured;
  logic [DATA_WIDTH-1:0] target;

  modport source (output valid, output command, output measured, output target,
                  input ready);
  modport sink   (input valid, input command, input measured, input target,
                  output ready);
endinterface

interface ipid_out_if import ipid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] drive;
  logic                  saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink   (input valid, input drive, input saturated, output ready);
endinterface

interface ipid_cfg_if import ipid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ipid_mac.sv
// Bit-serial multiply-accumulate of three gain/operand pairs, gain MSB first.
module ipid_mac import ipid_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  ipid_term_t [NUM_TERMS-1:0]    terms_i,
  output logic                          done_o,
  output logic signed [SUM_W-1:0]       acc_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [MAC_CNT_W-1:0]       cnt_q, cnt_d;
  ipid_term_t [NUM_TERMS-1:0] terms_q, terms_d;
  logic signed [SUM_W-1:0]    acc_q, acc_d;
  logic signed [SUM_W-1:0]    addend;

  // Add every operand whose gain bit is set, then double and accumulate
  always_comb begin
    addend = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (terms_q[k].mpy[GAIN_W-1]) begin
        addend = addend + SUM_W'($signed(terms_q[k].mcand));
      end
    end
  end

  // Advance one gain bit per cycle
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    terms_d = terms_q;
    acc_d   = acc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = MAC_CNT_W'(GAIN_W);
      terms_d = terms_i;
      acc_d   = '0;
    end else if (busy_q) begin
      acc_d = {acc_q[SUM_W-2:0], 1'b0} + addend;
      for (int k = 0; k < NUM_TERMS; k++) begin
        terms_d[k].mpy = {terms_q[k].mpy[GAIN_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MAC_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and sum
  always_ff @(posedge clk_i) begin
    terms_q <= terms_d;
    acc_q   <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

>>> hw/rtl/ipid_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitude by a 16-bit divisor.
module ipid_div import ipid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [MAG_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     divisor_q, divisor_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [MAG_W-1:0]     quo_q, quo_d;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = (trial >= {1'b0, divisor_q});

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = DIV_CNT_W'(MAG_W);
      divisor_d = divisor_i;
      rem_d     = '0;
      quo_d     = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_d = {quo_q[MAG_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold divisor, remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hw/rtl/integer_pid_anti_windup_top.sv
// Integer PID controller with integral anti-windup: sequencer, state and result register.
//
// Each input word runs through a bit-serial multiply-accumulate (one gain bit per
// cycle) and then a restoring divider (one quotient bit per cycle). A new input
// word is accepted only once the result of the previous one has been loaded into
// the result register; the result is registered and the next word is taken while
// it waits. A calculate word gives the control output clamped to [limit_low,
// limit_high] and a saturation flag; the integral only accumulates when the
// unclamped output lies within the limits. An init word clears the integral and
// the last error, computes the integral limit limit_high*divisor/gain_i on the
// same multiplier and divider, and returns drive 0.
// A divisor of 0 acts as 1.
// Configuration words are always taken and must be written while the block is idle.
module integer_pid_anti_windup_top import ipid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipid_cfg_if.sink   cfg_i,
  ipid_in_if.sink    in_i,
  ipid_out_if.source out_o
);

  // Configuration registers
  logic [GAIN_W-1:0]       gain_p_q, gain_i_q, gain_d_q;
  logic [DIV_W-1:0]        divisor_q;
  logic signed [LOW_W-1:0] limit_low_q;
  logic [HIGH_W-1:0]       limit_high_q;

  // Controller state
  logic [INTEG_W-1:0]      integral_q, integral_d;
  logic signed [ERR_W-1:0] last_error_q, last_error_d;
  logic [LIM_W-1:0]        limit_q, limit_d;

  // Per-word payload
  logic                    cmd_q;
  logic signed [ERR_W-1:0] err_q;
  logic                    sign_q;

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] drive_q, drive_d;
  logic                  saturated_q, saturated_d;

  // Sequencer
  ipid_state_e state_q, state_d;
  logic        in_ready, mac_start, div_start, load_out;

  // Datapath
  logic                         mac_done, div_done;
  logic signed [SUM_W-1:0]      mac_acc;
  logic [SUM_W-1:0]             mac_mag;
  logic [MAG_W-1:0]             quotient;
  logic [DIV_W-1:0]             div_eff, div_sel;
  ipid_term_t [NUM_TERMS-1:0]   terms;
  logic signed [ERR_W-1:0]      err_w;
  logic signed [DER_W-1:0]      der_w;
  logic signed [INTEG_W:0]      integ_s, limit_s, neg_limit_s;
  logic signed [INTEG_W-1:0]    integ_clamp;
  logic signed [SUM_W-1:0]      quo_s, raw, hi_s, lo_s, cv;
  logic                         above, below, in_limits;
  logic signed [SAT_W-1:0]      acc_sum;
  logic [INTEG_W-1:0]           integ_next;

  // Take configuration words
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      divisor_q    <= DIV_W'(1);
      limit_low_q  <= {1'b1, {(LOW_W-1){1'b0}}};
      limit_high_q <= {HIGH_W{1'b1}};
    end else if (cfg_i.valid) begin
      case (ipid_reg_e'(cfg_i.index))
        REG_GAIN_P:     gain_p_q     <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_I:     gain_i_q     <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_D:     gain_d_q     <= cfg_i.data[GAIN_W-1:0];
        REG_DIVISOR:    divisor_q    <= cfg_i.data[DIV_W-1:0];
        REG_LIMIT_LOW:  limit_low_q  <= $signed(cfg_i.data[LOW_W-1:0]);
        REG_LIMIT_HIGH: limit_high_q <= cfg_i.data[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign div_eff = (divisor_q == '0) ? DIV_W'(1) : divisor_q;

  // Form error and derivative, clamp the integral to the limit
  assign err_w = ERR_W'($signed(in_i.target)) - ERR_W'($signed(in_i.measured));
  assign der_w = DER_W'(err_w) - DER_W'(last_error_q);

  assign integ_s     = (INTEG_W+1)'($signed(integral_q));
  assign limit_s     = $signed((INTEG_W+1)'(limit_q));
  assign neg_limit_s = -limit_s;

  always_comb begin
    if (integ_s > limit_s) begin
      integ_clamp = limit_s[INTEG_W-1:0];
    end else if (integ_s < neg_limit_s) begin
      integ_clamp = neg_limit_s[INTEG_W-1:0];
    end else begin
      integ_clamp = integral_q;
    end
  end

  // Select multiply-accumulate operands
  always_comb begin
    if (in_i.command == CMD_INIT) begin
      terms[0].mpy   = limit_high_q;
      terms[0].mcand = MCAND_W'(div_eff);
      terms[1].mpy   = '0;
      terms[1].mcand = '0;
      terms[2].mpy   = '0;
      terms[2].mcand = '0;
    end else begin
      terms[0].mpy   = gain_p_q;
      terms[0].mcand = MCAND_W'(err_w);
      terms[1].mpy   = gain_i_q;
      terms[1].mcand = MCAND_W'(integ_clamp);
      terms[2].mpy   = gain_d_q;
      terms[2].mcand = MCAND_W'(der_w);
    end
  end

  ipid_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .terms_i (terms),
    .done_o  (mac_done),
    .acc_o   (mac_acc)
  );

  // Divide the magnitude of the sum, restore the sign afterwards
  assign mac_mag = mac_acc[SUM_W-1] ? (~mac_acc + 1'b1) : mac_acc;
  assign div_sel = (cmd_q == CMD_INIT) ? DIV_W'(gain_i_q) : div_eff;

  ipid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mac_mag[MAG_W-1:0]),
    .divisor_i  (div_sel),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Clamp the raw output and saturate the integral update
  assign quo_s = $signed({1'b0, quotient});
  assign raw   = sign_q ? -quo_s : quo_s;
  assign hi_s  = $signed(SUM_W'(limit_high_q));
  assign lo_s  = SUM_W'(limit_low_q);
  assign above     = (raw > hi_s);
  assign below     = (raw < lo_s);
  assign in_limits = !above && !below;
  assign cv        = above ? hi_s : (below ? lo_s : raw);

  assign acc_sum = SAT_W'($signed(integral_q)) + SAT_W'(err_q);

  always_comb begin
    if (acc_sum > $signed(SAT_W'($signed(INTEG_MAX)))) begin
      integ_next = INTEG_MAX;
    end else if (acc_sum < $signed(SAT_W'($signed(INTEG_MIN)))) begin
      integ_next = INTEG_MIN;
    end else begin
      integ_next = acc_sum[INTEG_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_MAC;
      ST_MAC:    if (mac_done) state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mac_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mac_start = in_i.valid;
      end
      ST_MAC:    div_start = mac_done;
      ST_DIV:    ;
      ST_FINISH: load_out  = !out_valid_q || out_o.ready;
      default:   ;
    endcase
  end

  assign in_i.ready = in_ready;

  // Update controller state and the result word
  always_comb begin
    integral_d   = integral_q;
    last_error_d = last_error_q;
    limit_d      = limit_q;
    drive_d      = drive_q;
    saturated_d  = saturated_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (mac_start) begin
      if (in_i.command == CMD_INIT) begin
        integral_d   = '0;
        last_error_d = '0;
      end else begin
        integral_d   = integ_clamp;
        last_error_d = err_w;
      end
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      if (cmd_q == CMD_INIT) begin
        limit_d     = (gain_i_q == '0) ? '0 : quotient[LIM_W-1:0];
        drive_d     = '0;
        saturated_d = 1'b0;
      end else begin
        if (in_limits) begin
          integral_d = integ_next;
        end
        drive_d     = cv[DATA_WIDTH-1:0];
        saturated_d = !in_limits;
      end
    end
  end

  // Hold control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      integral_q   <= '0;
      last_error_q <= '0;
      limit_q      <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      integral_q   <= integral_d;
      last_error_q <= last_error_d;
      limit_q      <= limit_d;
    end
  end

  // Hold per-word payload and result fields
  always_ff @(posedge clk_i) begin
    if (mac_start) begin
      cmd_q <= in_i.command;
      err_q <= err_w;
    end
    if (div_start) begin
      sign_q <= mac_acc[SUM_W-1];
    end
    drive_q     <= drive_d;
    saturated_q <= saturated_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.drive     = drive_q;
  assign out_o.saturated = saturated_q;

endmodule

>>> verif/ipid_control_checker.sv
// Checker that predicts and compares the control output words of the integer PID controller.
module ipid_control_checker import ipid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ipid_cfg_if         cfg_mon,
  ipid_in_if          in_mon,
  ipid_out_if         out_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;
  localparam longint ACC_HI = longint'($signed(INTEG_MAX));
  localparam longint ACC_LO = longint'($signed(INTEG_MIN));

  typedef struct packed {
    logic [DATA_WIDTH-1:0] drive;
    logic                  saturated;
  } ctrl_word_t;

  // Shadow copies of the configuration registers
  logic [GAIN_W-1:0]       gain_p_q;
  logic [GAIN_W-1:0]       gain_i_q;
  logic [GAIN_W-1:0]       gain_d_q;
  logic [DIV_W-1:0]        divisor_q;
  logic signed [LOW_W-1:0] limit_low_q;
  logic [HIGH_W-1:0]       limit_high_q;

  // Controller state, kept at full precision
  longint integral_q;
  longint last_error_q;
  longint integ_limit_q;

  ctrl_word_t  expected_ctrl_q[$];
  int unsigned fails;

  // Advance the controller by one input word and return its output word
  function automatic ctrl_word_t control_step(input logic cmd,
                                              input logic [DATA_WIDTH-1:0] pv,
                                              input logic [DATA_WIDTH-1:0] sp);
    longint     eff_div;
    longint     err;
    longint     der;
    longint     acc;
    longint     raw;
    longint     lo;
    longint     hi;
    longint     nxt;
    logic       in_range;
    ctrl_word_t res;
    eff_div = (divisor_q == '0) ? 64'sd1 : longint'(divisor_q);
    lo      = longint'(limit_low_q);
    hi      = longint'(limit_high_q);
    res     = '0;
    if (cmd == CMD_INIT) begin
      integral_q    = 0;
      last_error_q  = 0;
      integ_limit_q = (gain_i_q != '0) ? (hi * eff_div) / longint'(gain_i_q) : 64'sd0;
      return res;
    end
    err = longint'($signed(sp)) - longint'($signed(pv));
    der = err - last_error_q;
    // Clamp the integral before it is used
    if (integral_q > integ_limit_q) integral_q = integ_limit_q;
    if (integral_q < -integ_limit_q) integral_q = -integ_limit_q;
    acc = longint'(gain_p_q) * err + longint'(gain_i_q) * integral_q
        + longint'(gain_d_q) * der;
    raw = acc / eff_div;
    in_range = (raw <= hi) && (raw >= lo);
    // Accumulate only while the raw output stays within the limits
    if (in_range) begin
      nxt = integral_q + err;
      if (nxt > ACC_HI) nxt = ACC_HI;
      if (nxt < ACC_LO) nxt = ACC_LO;
      integral_q = nxt;
    end
    if (raw > hi) nxt = hi;
    else if (raw < lo) nxt = lo;
    else nxt = raw;
    last_error_q  = err;
    res.drive     = nxt[DATA_WIDTH-1:0];
    res.saturated = !in_range;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ctrl_word_t got;
    ctrl_word_t want;
    if (!rst_ni) begin
      gain_p_q      = '0;
      gain_i_q      = '0;
      gain_d_q      = '0;
      divisor_q     = 16'd1;
      limit_low_q   = 16'sh8000;
      limit_high_q  = 15'h7FFF;
      integral_q    = 0;
      last_error_q  = 0;
      integ_limit_q = 0;
      fails         = 0;
      expected_ctrl_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Track register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_GAIN_P:     gain_p_q     = cfg_mon.data[GAIN_W-1:0];
          REG_GAIN_I:     gain_i_q     = cfg_mon.data[GAIN_W-1:0];
          REG_GAIN_D:     gain_d_q     = cfg_mon.data[GAIN_W-1:0];
          REG_DIVISOR:    divisor_q    = cfg_mon.data[DIV_W-1:0];
          REG_LIMIT_LOW:  limit_low_q  = cfg_mon.data[LOW_W-1:0];
          REG_LIMIT_HIGH: limit_high_q = cfg_mon.data[HIGH_W-1:0];
          default: ;
        endcase
      end
      // Compare an output word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.drive     = out_mon.drive;
        got.saturated = out_mon.saturated;
        if (expected_ctrl_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected output word drive %0d saturated %0b",
                     $realtime, $signed(got.drive), got.saturated);
        end else begin
          want = expected_ctrl_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: output mismatch: drive exp %0d got %0d, saturated exp %0b got %0b",
                       $realtime, $signed(want.drive), $signed(got.drive),
                       want.saturated, got.saturated);
          end
        end
      end
      // Predict the output of an accepted input word
      if (in_mon.valid && in_mon.ready)
        expected_ctrl_q.push_back(control_step(in_mon.command, in_mon.measured,
                                               in_mon.target));
      pending_o    <= expected_ctrl_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> verif/integer_pid_anti_windup_top_test.sv
// Top of the integer PID controller testbench: clock, reset, stimulus and verdict.
module integer_pid_anti_windup_top_test import ipid_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime     CLK_PERIOD      = 12ns;
  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES     = 100;
  localparam int unsigned PHASES_PER_MODE = 6;
  localparam int unsigned ITEMS_PER_PHASE = 30;

  // Unassigned register indexes, written once to see that they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [DATA_WIDTH-1:0] CORNER_VALS [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned snd_idle_pct = 36;
  int unsigned rcv_idle_pct = 76;
  bit          hold_req = 1'b0;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;

  ipid_cfg_if pid_cfg ();
  ipid_in_if  pid_in ();
  ipid_out_if pid_out ();

  integer_pid_anti_windup_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (pid_cfg),
    .in_i   (pid_in),
    .out_o  (pid_out)
  );

  ipid_control_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (pid_cfg),
    .in_mon       (pid_in),
    .out_mon      (pid_out),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort when no channel moves a word for too long
  always @(posedge clk_i) begin
    if ((pid_in.valid && pid_in.ready) || (pid_out.valid && pid_out.ready) ||
        (pid_cfg.valid && pid_cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("integer_pid_anti_windup_top verification failed");
      $finish;
    end
  end

  // Output side: random backpressure, plus one long hold-off on request
  initial begin
    pid_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pid_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pid_out.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Write one register; valid stays high for a following write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    pid_cfg.valid <= 1'b1;
    pid_cfg.index <= idx;
    pid_cfg.data  <= value;
    do @(posedge clk_i); while (!pid_cfg.ready);
  endtask

  task automatic program_regs(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic [15:0] div,
                              input logic [15:0] lo, input logic [15:0] hi);
    cfg_write(REG_GAIN_P, kp);
    cfg_write(REG_GAIN_I, ki);
    cfg_write(REG_GAIN_D, kd);
    cfg_write(REG_DIVISOR, div);
    cfg_write(REG_LIMIT_LOW, lo);
    cfg_write(REG_LIMIT_HIGH, hi);
    pid_cfg.valid <= 1'b0;
  endtask

  // Offer one input word after a random gap and wait until it is taken
  task automatic send_word(input logic cmd, input logic [DATA_WIDTH-1:0] pv,
                           input logic [DATA_WIDTH-1:0] sp);
    while ($urandom_range(99) < snd_idle_pct) begin
      pid_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pid_in.valid    <= 1'b1;
    pid_in.command  <= cmd;
    pid_in.measured <= pv;
    pid_in.target   <= sp;
    do @(posedge clk_i); while (!pid_in.ready);
  endtask

  // Drop the input and wait until every predicted word has come out
  task automatic wait_drained();
    pid_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Pick a random register setting, from tame to extreme
  task automatic random_regs();
    logic [15:0] gains [3];
    logic [15:0] div;
    logic [15:0] lo;
    logic [15:0] hi;
    for (int g = 0; g < 3; g++) begin
      case ($urandom_range(3))
        0:       gains[g] = 16'($urandom_range(8));
        1:       gains[g] = 16'($urandom_range(300));
        2:       gains[g] = 16'($urandom);
        default: gains[g] = 16'hFFFF;
      endcase
    end
    case ($urandom_range(5))
      0:       div = '0;
      1:       div = 16'd1;
      2:       div = 16'($urandom_range(64, 2));
      3:       div = 16'($urandom_range(4096, 65));
      4:       div = 16'($urandom);
      default: div = 16'hFFFF;
    endcase
    case ($urandom_range(3))
      0:       hi = '0;
      1:       hi = 16'h7FFF;
      default: hi = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0:       lo = 16'h8000;
      1, 2:    lo = ~16'($urandom_range(32767));
      3:       lo = 16'($urandom);
      default: lo = 16'($urandom_range(300));
    endcase
    program_regs(gains[0], gains[1], gains[2], div, lo, hi);
  endtask

  // Mostly tracking sequences where the process value follows the setpoint
  task automatic random_phase(input int unsigned n_items);
    logic [DATA_WIDTH-1:0] base;
    logic [DATA_WIDTH-1:0] pv;
    logic [DATA_WIDTH-1:0] sp;
    int unsigned           pick;
    base = 16'($urandom);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word(CMD_INIT, 16'($urandom), 16'($urandom));
      end else begin
        if (pick < 60) begin
          base = base + 16'($urandom_range(64)) - 16'd32;
          sp   = base;
          pv   = sp + 16'($urandom_range(200)) - 16'd100;
        end else if (pick < 70) begin
          sp = CORNER_VALS[$urandom_range(3)];
          pv = CORNER_VALS[$urandom_range(3)];
        end else begin
          sp = 16'($urandom);
          pv = 16'($urandom);
        end
        send_word(CMD_CALC, pv, sp);
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    pid_cfg.valid   <= 1'b0;
    pid_cfg.index   <= REG_GAIN_P;
    pid_cfg.data    <= '0;
    pid_in.valid    <= 1'b0;
    pid_in.command  <= CMD_CALC;
    pid_in.measured <= '0;
    pid_in.target   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: all gains zero, so the output stays at zero
    send_word(CMD_CALC, 16'h0000, 16'h0000);
    send_word(CMD_CALC, 16'h8000, 16'h7FFF);
    send_word(CMD_INIT, 16'h7FFF, 16'h8000);
    wait_drained();

    // Largest gains and divisor; gain writes carry a set top bit
    cfg_write(REG_SPARE_A, 16'hFFFF);
    cfg_write(REG_SPARE_B, 16'h5A5A);
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_word(CMD_INIT, 16'h0000, 16'h0000);
    send_word(CMD_CALC, 16'h7FFF, 16'h8000);
    send_word(CMD_CALC, 16'h8000, 16'h7FFF);
    send_word(CMD_CALC, 16'h0000, 16'h0000);
    wait_drained();

    // Zero divisor acts as one
    program_regs(16'd3, 16'd1, 16'd2, 16'd0, -16'sd1000, 16'd1000);
    send_word(CMD_INIT, 16'h0000, 16'h0000);
    send_word(CMD_CALC, 16'd10, 16'd50);
    send_word(CMD_CALC, 16'd40, 16'd50);
    send_word(CMD_CALC, 16'd60, 16'd50);
    send_word(CMD_CALC, 16'd900, 16'd0);
    wait_drained();

    // Crossed limits: low above high
    program_regs(16'd1, 16'd1, 16'd0, 16'd1, 16'd200, 16'd100);
    send_word(CMD_INIT, 16'h0000, 16'h0000);
    send_word(CMD_CALC, 16'd0, 16'd150);
    send_word(CMD_CALC, 16'd0, 16'd300);
    send_word(CMD_CALC, 16'd0, 16'd50);
    send_word(CMD_CALC, 16'd5, 16'd0);
    wait_drained();

    // Integral clamp at a small limit, then a swing negative
    program_regs(16'd0, 16'd1, 16'd0, 16'd1, 16'h8000, 16'd10);
    send_word(CMD_INIT, 16'h0000, 16'h0000);
    repeat (5) send_word(CMD_CALC, 16'd0, 16'd4);
    send_word(CMD_CALC, 16'd30, 16'd0);
    wait_drained();

    // Random part: three idling modes, each with several register settings
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          snd_idle_pct = 36;
          rcv_idle_pct = 76;
        end
        1: begin
          snd_idle_pct = 76;
          rcv_idle_pct = 36;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
        wait_drained();
        random_regs();
        send_word(CMD_INIT, 16'($urandom), 16'($urandom));
        // Back up the pipeline once while words keep coming
        if (mode == 2 && ph == 0) hold_req = 1'b1;
        random_phase(ITEMS_PER_PHASE);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("integer_pid_anti_windup_top verification clean");
    end else begin
      $display("integer_pid_anti_windup_top verification failed");
    end
    $finish;
  end

endmodule
